>>> hw/rtl/rlst_pkg.sv
// shared types, codes and reset values for the rgb led serial transmitter
package rlst_pkg;

  localparam int unsigned MaxLedsDefault    = 255;
  localparam int unsigned BitsPerLedDefault = 24;
  localparam int unsigned QueueDepth        = 4;
  localparam int unsigned ColourW           = 24;

  localparam logic [7:0]  LedTotalReset  = 8'd1;
  localparam logic [15:0] OneHighReset   = 16'd12;
  localparam logic [15:0] OneLowReset    = 16'd10;
  localparam logic [15:0] ZeroHighReset  = 16'd3;
  localparam logic [15:0] ZeroLowReset   = 16'd8;
  localparam logic [15:0] LatchReset     = 16'd10;
  localparam logic        InvertReset    = 1'b1;

  typedef enum logic [1:0] {
    PhIdle  = 2'd0,
    PhLatch = 2'd1,
    PhHigh  = 2'd2,
    PhLow   = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ClsBlue   = 3'd0,
    ClsGreen  = 3'd1,
    ClsRed    = 3'd2,
    ClsYellow = 3'd3,
    ClsOther  = 3'd4
  } colour_class_e;

  typedef enum logic [2:0] {
    RegLedTotal  = 3'd0,
    RegOneHigh   = 3'd1,
    RegOneLow    = 3'd2,
    RegZeroHigh  = 3'd3,
    RegZeroLow   = 3'd4,
    RegLatch     = 3'd5,
    RegInvert    = 3'd6
  } reg_idx_e;

  // one queued command from the front end
  typedef struct packed {
    logic                 load;
    colour_class_e        cls;
    logic [ColourW-1:0]   word;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  led_total;
    logic [15:0] one_high;
    logic [15:0] one_low;
    logic [15:0] zero_high;
    logic [15:0] zero_low;
    logic [15:0] latch;
    logic        invert;
  } cfg_t;

  // lowest bit first: line_level, busy_res, colour_class, load_refused
  typedef struct packed {
    logic          load_refused;
    colour_class_e colour_class;
    logic          busy_res;
    logic          line_level;
  } result_t;

endpackage

>>> hw/rtl/rlst_front.sv
// front end: accepts words, masks missing bytes and classifies the colour
module rlst_front (
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [31:0]       s_axis_tdata,  // red, green, blue, byte_count, zero fill
  input  logic              s_axis_tuser,  // action
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output rlst_pkg::cmd_t    push_cmd_o
);
  import rlst_pkg::*;

  logic [1:0] byte_count;
  logic [7:0] red, green, blue;
  logic       r_nz, g_nz, b_nz;
  colour_class_e cls;

  assign byte_count = s_axis_tdata[25:24];
  assign red   = (byte_count >= 2'd1) ? s_axis_tdata[7:0]   : 8'd0;
  assign green = (byte_count >= 2'd2) ? s_axis_tdata[15:8]  : 8'd0;
  assign blue  = (byte_count == 2'd3) ? s_axis_tdata[23:16] : 8'd0;

  assign r_nz = |red;
  assign g_nz = |green;
  assign b_nz = |blue;

  always_comb begin
    unique case ({r_nz, g_nz, b_nz})
      3'b001:  cls = ClsBlue;
      3'b010:  cls = ClsGreen;
      3'b100:  cls = ClsRed;
      3'b110:  cls = ClsYellow;
      default: cls = ClsOther;
    endcase
  end

  assign push_valid_o    = s_axis_tvalid;
  assign s_axis_tready   = push_ready_i;
  assign push_cmd_o.load = s_axis_tuser;
  assign push_cmd_o.cls  = cls;
  assign push_cmd_o.word = {green, red, blue};

endmodule

>>> hw/rtl/rlst_queue.sv
// small command queue between front end and waveform engine
module rlst_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  rlst_pkg::cmd_t push_cmd_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output rlst_pkg::cmd_t pop_cmd_o
);
  import rlst_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign push = push_valid_i & push_ready_o;
  assign pop  = pop_valid_o & pop_ready_i;
  assign pop_cmd_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ((wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop  ? ((rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth)) else $error("queue count overflow");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q)) else $error("queue pointers disagree when empty");

endmodule

>>> hw/rtl/rlst_back.sv
// waveform engine: runs the latch and bit phases and registers one result per command
module rlst_back #(
  parameter int unsigned MAX_LEDS     = rlst_pkg::MaxLedsDefault,
  parameter int unsigned BITS_PER_LED = rlst_pkg::BitsPerLedDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rlst_pkg::cfg_t cfg_i,
  input  logic           pop_valid_i,
  output logic           pop_ready_o,
  input  rlst_pkg::cmd_t pop_cmd_i,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [7:0]     m_axis_tdata   // line_level, busy_res, colour_class, load_refused
);
  import rlst_pkg::*;

  localparam int unsigned BitW   = $clog2(BITS_PER_LED);
  localparam int unsigned LedCap = (MAX_LEDS > 255) ? 255 : MAX_LEDS;

  logic [ColourW-1:0]      word_q, word_d;
  logic [BitW-1:0]         bit_q, bit_d;
  logic [7:0]              leds_q, leds_d;
  phase_e                  phase_q, phase_d;
  logic [15:0]             tick_q, tick_d;
  colour_class_e           cls_q, cls_d;
  logic                    out_valid_q, out_valid_d;
  result_t                 out_q, res;

  logic                    fire;
  logic [16:0]             tick_inc;
  logic [BITS_PER_LED-1:0] word_ext;
  logic [BitW-1:0]         bit_idx;
  logic                    cur_bit;
  logic [15:0]             high_len, low_len;
  logic                    idle_pin;
  logic [7:0]              leds_dec;

  assign pop_ready_o = ~out_valid_q | m_axis_tready;
  assign fire        = pop_valid_i & pop_ready_o;

  assign tick_inc = {1'b0, tick_q} + 17'd1;
  assign word_ext = BITS_PER_LED'(word_q);
  assign bit_idx  = BitW'(BITS_PER_LED - 1) - bit_q;
  assign cur_bit  = word_ext[bit_idx];
  assign high_len = cur_bit ? cfg_i.one_high : cfg_i.zero_high;
  assign low_len  = cur_bit ? cfg_i.one_low  : cfg_i.zero_low;
  assign idle_pin = cfg_i.invert;

  always_comb begin
    word_d  = word_q;
    bit_d   = bit_q;
    leds_d  = leds_q;
    phase_d = phase_q;
    tick_d  = tick_q;
    cls_d   = cls_q;
    leds_dec = leds_q;
    res.line_level   = idle_pin;
    res.busy_res     = 1'b0;
    res.load_refused = 1'b0;

    if (pop_cmd_i.load) begin
      if (phase_q != PhIdle) begin
        // busy: drop the load, report the level being held
        res.load_refused = 1'b1;
        res.busy_res     = 1'b1;
        res.line_level   = (phase_q == PhHigh) ? ~idle_pin : idle_pin;
      end else begin
        cls_d   = pop_cmd_i.cls;
        word_d  = pop_cmd_i.word;
        leds_d  = (cfg_i.led_total > 8'(LedCap)) ? 8'(LedCap) : cfg_i.led_total;
        bit_d   = '0;
        tick_d  = '0;
        phase_d = PhLatch;
        res.busy_res = 1'b1;
      end
    end else begin
      unique case (phase_q)
        PhIdle: begin
        end
        PhLatch: begin
          res.busy_res = 1'b1;
          tick_d = tick_inc[15:0];
          if (tick_inc >= {1'b0, cfg_i.latch}) begin
            tick_d  = '0;
            phase_d = (leds_q == '0) ? PhIdle : PhHigh;
          end
        end
        PhHigh: begin
          res.busy_res   = 1'b1;
          res.line_level = ~idle_pin;
          tick_d = tick_inc[15:0];
          if (tick_inc >= {1'b0, high_len}) begin
            tick_d  = '0;
            phase_d = PhLow;
          end
        end
        PhLow: begin
          res.busy_res = 1'b1;
          tick_d = tick_inc[15:0];
          if (tick_inc >= {1'b0, low_len}) begin
            tick_d = '0;
            bit_d  = bit_q + 1'b1;
            if (bit_q == BitW'(BITS_PER_LED - 1)) begin
              bit_d = '0;
              if (leds_q != '0) begin
                leds_dec = leds_q - 1'b1;
              end
            end
            leds_d = leds_dec;
            if (leds_dec == '0) begin
              phase_d = PhIdle;
              bit_d   = '0;
            end else begin
              phase_d = PhHigh;
            end
          end
        end
        default: begin
        end
      endcase
    end
    res.colour_class = cls_d;
  end

  assign out_valid_d = fire | (out_valid_q & ~m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q      <= '0;
      bit_q       <= '0;
      leds_q      <= '0;
      phase_q     <= PhIdle;
      tick_q      <= '0;
      cls_q       <= ClsOther;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (fire) begin
        word_q  <= word_d;
        bit_q   <= bit_d;
        leds_q  <= leds_d;
        phase_q <= phase_d;
        tick_q  <= tick_d;
        cls_q   <= cls_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q};

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhIdle) |-> (bit_q == '0 && tick_q == '0)) else $error("idle with stale counters");

  a_bit_phase_has_led: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhHigh || phase_q == PhLow) |-> (leds_q != '0)) else $error("bit phase with no leds");

  a_refused_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && res.load_refused) |-> (res.busy_res && phase_q != PhIdle)) else $error("refusal while idle");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> m_axis_tvalid) else $error("command lost before output");

endmodule

>>> hw/rtl/rgb_led_serial_transmitter.sv
// top level of the rgb led serial transmitter with its register file
//
// usage:
//   s_axis carries one word per waveform tick or colour load. tuser is the action
//   (0: one tick passes, 1: load a colour); tdata carries red, green, blue and
//   byte_count, where bytes beyond byte_count read as zero.
//   m_axis returns exactly one word per input word: the pin level, busy flag,
//   current colour class and a flag for a load refused while a frame runs.
//   the apb port holds led count, the four bit phase lengths, the latch length
//   and line polarity; write it only while no word is in flight.
// timing:
//   an accepted input word is written into the command queue; its result is
//   registered in the output register when the engine takes it from the queue,
//   and shows on m_axis from there. one word per clock is sustained while m_axis
//   is not stalled; the waveform engine retires one command per cycle unless
//   m_axis stalls, and its longest path is the 16-bit tick increment and compare.
// reset:
//   registers return to their defaults, the queue empties and the engine goes
//   idle with class other. a stalled m_axis fills the 4-entry queue, after
//   which s_axis_tready drops until the receiver takes words again.
module rgb_led_serial_transmitter #(
  parameter int unsigned MAX_LEDS     = rlst_pkg::MaxLedsDefault,
  parameter int unsigned BITS_PER_LED = rlst_pkg::BitsPerLedDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16], byte_count[25:24]
  input  logic        s_axis_tuser,   // action
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // line_level[0], busy_res[1], colour_class[4:2], load_refused[5]
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rlst_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     cfg_wr;

  logic     push_valid, push_ready;
  cmd_t     push_cmd;
  logic     pop_valid, pop_ready;
  cmd_t     pop_cmd;

  // register file: word-aligned, index in paddr[4:2]
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.led_total <= LedTotalReset;
      cfg_q.one_high  <= OneHighReset;
      cfg_q.one_low   <= OneLowReset;
      cfg_q.zero_high <= ZeroHighReset;
      cfg_q.zero_low  <= ZeroLowReset;
      cfg_q.latch     <= LatchReset;
      cfg_q.invert    <= InvertReset;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegLedTotal: cfg_q.led_total <= pwdata[7:0];
        RegOneHigh:  cfg_q.one_high  <= pwdata[15:0];
        RegOneLow:   cfg_q.one_low   <= pwdata[15:0];
        RegZeroHigh: cfg_q.zero_high <= pwdata[15:0];
        RegZeroLow:  cfg_q.zero_low  <= pwdata[15:0];
        RegLatch:    cfg_q.latch     <= pwdata[15:0];
        RegInvert:   cfg_q.invert    <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegLedTotal: prdata = {24'd0, cfg_q.led_total};
      RegOneHigh:  prdata = {16'd0, cfg_q.one_high};
      RegOneLow:   prdata = {16'd0, cfg_q.one_low};
      RegZeroHigh: prdata = {16'd0, cfg_q.zero_high};
      RegZeroLow:  prdata = {16'd0, cfg_q.zero_low};
      RegLatch:    prdata = {16'd0, cfg_q.latch};
      RegInvert:   prdata = {31'd0, cfg_q.invert};
      default:     prdata = '0;
    endcase
  end

  // front end: byte masking and colour classification
  rlst_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_cmd_o    (push_cmd)
  );

  // decouples the input side from the engine and output stalls
  rlst_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  // waveform engine and output register
  rlst_back #(
    .MAX_LEDS     (MAX_LEDS),
    .BITS_PER_LED (BITS_PER_LED)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_cmd_i     (pop_cmd),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

>>> sim/rgb_led_serial_transmitter_tb.sv
// self-checking testbench for the rgb led serial transmitter: stream stimulus, waveform predictor
module rgb_led_serial_transmitter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rlst_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  // one input word as the driver sees it
  typedef struct packed {
    logic       action;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] count;
  } tick_load_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [7:0]  m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  rgb_led_serial_transmitter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_tdata),   // red[7:0], green[15:8], blue[23:16], byte_count[25:24]
    .s_axis_tuser  (s_tuser),   // action
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_tdata),   // line_level, busy_res, colour_class[2:0], load_refused
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // words waiting for the driver, and results the line model says are due
  tick_load_t stim_q[$];
  result_t    due_results[$];

  int unsigned cycles = 0;
  int unsigned mismatches = 0;

  // --------------------------------------------------------------------------
  // line model: its own copy of the registers and the frame state
  // --------------------------------------------------------------------------
  cfg_t          ln_cfg;
  logic [23:0]   ln_word;
  int unsigned   ln_bit;
  int unsigned   ln_leds;
  phase_e        ln_phase;
  int unsigned   ln_ticks;
  colour_class_e ln_class;

  // ends a latch or a bit: next bit if leds remain, else back to idle
  function automatic void next_bit_or_idle();
    ln_ticks = 0;
    if (ln_leds == 0) begin
      ln_phase = PhIdle;
      ln_bit   = 0;
    end else begin
      ln_phase = PhHigh;
    end
  endfunction

  // one accepted word in, the expected result word out
  function automatic result_t waveform_step(input tick_load_t w);
    result_t     res;
    logic        idle_pin;
    logic        bit_val;
    logic [7:0]  r, g, b;
    int unsigned len;
    idle_pin = ln_cfg.invert;
    res = '0;
    res.line_level = idle_pin;
    if (w.action) begin
      if (ln_phase != PhIdle) begin
        // load during a frame: dropped, nothing advances
        res.load_refused = 1'b1;
        res.busy_res     = 1'b1;
        res.line_level   = (ln_phase == PhHigh) ? ~idle_pin : idle_pin;
      end else begin
        // bytes past the count read as zero
        r = (w.count >= 2'd1) ? w.red   : 8'd0;
        g = (w.count >= 2'd2) ? w.green : 8'd0;
        b = (w.count >= 2'd3) ? w.blue  : 8'd0;
        if (r == 0 && g == 0 && b != 0)      ln_class = ClsBlue;
        else if (r == 0 && g != 0 && b == 0) ln_class = ClsGreen;
        else if (r != 0 && g == 0 && b == 0) ln_class = ClsRed;
        else if (r != 0 && g != 0 && b == 0) ln_class = ClsYellow;
        else                                 ln_class = ClsOther;
        ln_word  = {g, r, b};
        ln_leds  = (int'(ln_cfg.led_total) > MaxLedsDefault) ? MaxLedsDefault
                                                              : 32'(ln_cfg.led_total);
        ln_bit   = 0;
        ln_ticks = 0;
        ln_phase = PhLatch;
        res.busy_res = 1'b1;
      end
    end else if (ln_phase != PhIdle) begin
      res.busy_res = 1'b1;
      ln_ticks++;
      bit_val = ln_word[23 - ln_bit];
      case (ln_phase)
        PhLatch: begin
          if (ln_ticks >= ln_cfg.latch) next_bit_or_idle();
        end
        PhHigh: begin
          res.line_level = ~idle_pin;
          len = 32'(bit_val ? ln_cfg.one_high : ln_cfg.zero_high);
          if (ln_ticks >= len) begin
            ln_ticks = 0;
            ln_phase = PhLow;
          end
        end
        default: begin
          len = 32'(bit_val ? ln_cfg.one_low : ln_cfg.zero_low);
          if (ln_ticks >= len) begin
            ln_bit++;
            if (ln_bit >= BitsPerLedDefault) begin
              ln_bit = 0;
              if (ln_leds > 0) ln_leds--;
            end
            next_bit_or_idle();
          end
        end
      endcase
    end
    res.colour_class = ln_class;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // idle lengths: mostly none or short, a few long, now and then a clean run
  // --------------------------------------------------------------------------
  function automatic int idle_len(inout int run);
    int pick;
    if (run > 0) begin
      run--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      run = $urandom_range(20, 60);
      return 0;
    end
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // driver: new word at the falling edge once the previous one was taken
  // --------------------------------------------------------------------------
  logic in_took = 1'b0;
  int   in_gap = 0;
  int   in_run = 0;
  int   out_hold = 0;
  int   out_run = 0;

  always @(negedge clk_i) begin
    tick_load_t w;
    if (rst_ni) begin
      if (!s_valid || in_took) begin
        if (in_gap > 0) begin
          s_valid <= 1'b0;
          in_gap--;
        end else if (stim_q.size() > 0) begin
          w = stim_q.pop_front();
          s_valid <= 1'b1;
          s_tdata <= {6'd0, w.count, w.blue, w.green, w.red};
          s_tuser <= w.action;
          in_gap = idle_len(in_run);
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_hold > 0) begin
        m_ready <= 1'b0;
        out_hold--;
      end else begin
        m_ready <= 1'b1;
        out_hold = idle_len(out_run);
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: predict on input handshake, check on output handshake
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    tick_load_t w;
    result_t    got;
    result_t    want;
    if (rst_ni) begin
      in_took <= s_valid && s_ready;
      if (s_valid && s_ready) begin
        w.action = s_tuser;
        w.red    = s_tdata[7:0];
        w.green  = s_tdata[15:8];
        w.blue   = s_tdata[23:16];
        w.count  = s_tdata[25:24];
        due_results.push_back(waveform_step(w));
      end
      if (m_valid && m_ready) begin
        got = m_tdata[5:0];
        if (due_results.size() == 0) begin
          $error("result word 0x%0h with nothing expected", m_tdata);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (got.line_level !== want.line_level) begin
            $error("line_level: expected %0d, got %0d", want.line_level, got.line_level);
            mismatches++;
          end
          if (got.busy_res !== want.busy_res) begin
            $error("busy_res: expected %0d, got %0d", want.busy_res, got.busy_res);
            mismatches++;
          end
          if (got.colour_class !== want.colour_class) begin
            $error("colour_class: expected %0d, got %0d", want.colour_class,
                   got.colour_class);
            mismatches++;
          end
          if (got.load_refused !== want.load_refused) begin
            $error("load_refused: expected %0d, got %0d", want.load_refused,
                   got.load_refused);
            mismatches++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  task automatic reg_write(input reg_idx_e idx, input logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    // register takes the value at the rising edge in between
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegLedTotal: ln_cfg.led_total = val[7:0];
      RegOneHigh:  ln_cfg.one_high  = val[15:0];
      RegOneLow:   ln_cfg.one_low   = val[15:0];
      RegZeroHigh: ln_cfg.zero_high = val[15:0];
      RegZeroLow:  ln_cfg.zero_low  = val[15:0];
      RegLatch:    ln_cfg.latch     = val[15:0];
      default:     ln_cfg.invert    = val[0];
    endcase
  endtask

  task automatic set_registers(input cfg_t c);
    reg_write(RegLedTotal, 32'(c.led_total));
    reg_write(RegOneHigh,  32'(c.one_high));
    reg_write(RegOneLow,   32'(c.one_low));
    reg_write(RegZeroHigh, 32'(c.zero_high));
    reg_write(RegZeroLow,  32'(c.zero_low));
    reg_write(RegLatch,    32'(c.latch));
    reg_write(RegInvert,   32'(c.invert));
  endtask

  // every word taken and every result back, then extra slack
  task automatic drain();
    while (stim_q.size() != 0 || s_valid || due_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  function automatic logic [7:0] colour_byte();
    return ($urandom_range(0, 9) < 4) ? 8'd0 : 8'($urandom_range(1, 255));
  endfunction

  function automatic tick_load_t rand_word(input int load_pct);
    tick_load_t w;
    w.action = ($urandom_range(0, 99) < load_pct);
    w.red    = colour_byte();
    w.green  = colour_byte();
    w.blue   = colour_byte();
    w.count  = 2'($urandom_range(0, 3));
    return w;
  endfunction

  task automatic queue_word(input logic act, input logic [7:0] r, g, b,
                            input logic [1:0] n);
    stim_q.push_back({act, r, g, b, n});
  endtask

  task automatic run_random(input cfg_t c, input int n, input int load_pct);
    set_registers(c);
    repeat (n) stim_q.push_back(rand_word(load_pct));
    drain();
  endtask

  initial begin
    ln_cfg   = {LedTotalReset, OneHighReset, OneLowReset, ZeroHighReset, ZeroLowReset,
                LatchReset, InvertReset};
    ln_word  = '0;
    ln_bit   = 0;
    ln_leds  = 0;
    ln_phase = PhIdle;
    ln_ticks = 0;
    ln_class = ClsOther;

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: no leds and a one-tick latch, so each load clears in one tick
    set_registers({8'd0, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 1'b1});
    queue_word(1'b0, 8'h00, 8'h00, 8'h00, 2'd0);   // tick while idle, all low
    queue_word(1'b0, 8'hff, 8'hff, 8'hff, 2'd3);   // tick while idle, all high
    queue_word(1'b1, 8'h00, 8'h00, 8'hff, 2'd3);   // blue
    queue_word(1'b1, 8'hff, 8'hff, 8'hff, 2'd3);   // load while busy is refused
    queue_word(1'b0, 8'h00, 8'h00, 8'h00, 2'd0);
    queue_word(1'b1, 8'h00, 8'hff, 8'h00, 2'd3);   // green
    queue_word(1'b0, 8'h00, 8'h00, 8'h00, 2'd0);
    queue_word(1'b1, 8'hff, 8'hff, 8'hff, 2'd1);   // red, green and blue masked off
    queue_word(1'b0, 8'h00, 8'h00, 8'h00, 2'd0);
    queue_word(1'b1, 8'hff, 8'h80, 8'hff, 2'd2);   // yellow, blue masked off
    queue_word(1'b0, 8'h00, 8'h00, 8'h00, 2'd0);
    queue_word(1'b1, 8'hff, 8'hff, 8'hff, 2'd0);   // nothing valid: other
    queue_word(1'b0, 8'h00, 8'h00, 8'h00, 2'd0);
    queue_word(1'b1, 8'h01, 8'h01, 8'h01, 2'd3);   // all nonzero: other
    queue_word(1'b0, 8'h00, 8'h00, 8'h00, 2'd0);
    queue_word(1'b1, 8'h00, 8'h00, 8'hff, 2'd2);   // blue masked: all zero, other
    queue_word(1'b0, 8'h00, 8'h00, 8'h00, 2'd0);
    drain();

    // default timing, one led; the frame runs on past the phase end
    run_random({8'd1, 16'd12, 16'd10, 16'd3, 16'd8, 16'd10, 1'b1}, 120, 5);
    // shortest phases, normal polarity, two leds
    run_random({8'd2, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 1'b0}, 150, 4);
    run_random({8'd1, 16'd2, 16'd1, 16'd1, 16'd2, 16'd3, 1'b1}, 150, 5);
    // zero length registers behave as one tick
    run_random({8'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0}, 80, 8);
    // longest phases: frame stalls in the latch
    run_random({8'd3, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1}, 30, 10);
    // full led count without a load: must not touch the running frame
    run_random({8'd255, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b0}, 20, 0);
    // shrink the phases mid-frame and let it finish
    run_random({8'd3, 16'd1, 16'd2, 16'd2, 16'd1, 16'd1, 1'b0}, 150, 5);

    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
